### src/stride_prefetch_table_assert.svh
// ---------------------------------------------------------------------------
// stride_prefetch_table_assert: assertion macros
// Shorthand for clocked assertions that use clk_i and rst_ni.
// ---------------------------------------------------------------------------
`ifndef STRIDE_PREFETCH_TABLE_ASSERT_SVH
`define STRIDE_PREFETCH_TABLE_ASSERT_SVH

// antecedent and consequent in the same cycle
`define SPT_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define SPT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/spt_pkg.sv
// ---------------------------------------------------------------------------
// spt_pkg: shared types for the stride prefetch table
// Transaction payloads, table entry layout and confidence codes.
// ---------------------------------------------------------------------------
package spt_pkg;

  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned STRIDE_W = 32;

  typedef enum logic [1:0] {
    CONF_INIT      = 2'd0,
    CONF_TRANSIENT = 2'd1,
    CONF_STEADY    = 2'd2,
    CONF_NOPRED    = 2'd3
  } conf_e;

  typedef struct packed {
    logic [ADDR_W-1:0] instr_addr;
    logic [ADDR_W-1:0] data_addr;
  } in_item_t;

  typedef struct packed {
    logic              prefetch_valid;
    logic [ADDR_W-1:0] prefetch_addr;
  } out_item_t;

  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   tag;
    logic [ADDR_W-1:0]   last_addr;
    logic [STRIDE_W-1:0] stride;
    conf_e               conf;
  } entry_t;

endpackage

### src/spt_index.sv
// ---------------------------------------------------------------------------
// spt_index: table index from the instruction address
// Low bits for a power-of-two table; otherwise a three-stage reduction:
// byte folding by constant weights, a reciprocal multiply, then a subtract.
// ---------------------------------------------------------------------------
module spt_index import spt_pkg::*; #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned IW      = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ADDR_W-1:0] pc_i,
  output logic              done_o,
  output logic [IW-1:0]     idx_o
);

  localparam bit IS_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);

  if (IS_POW2) begin : g_mask
    assign done_o = start_i;
    assign idx_o  = pc_i[IW-1:0] & IW'(ENTRIES - 1);
  end else begin : g_recip
    localparam int unsigned CHUNKS = ADDR_W / 8;
    localparam int unsigned PART_W = IW + 8;
    localparam int unsigned FOLD_W = PART_W + $clog2(CHUNKS);
    localparam int unsigned SHIFT  = FOLD_W + IW;
    localparam int unsigned QUO_W  = FOLD_W + 1 - IW;
    localparam int unsigned PROD_W = 2 * FOLD_W + 1;
    localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + ENTRIES - 1) / ENTRIES;
    localparam logic [FOLD_W:0] RECIP   = (FOLD_W + 1)'(RECIP_L);
    localparam logic [IW:0]     MODULUS = (IW + 1)'(ENTRIES);

    logic [PART_W-1:0] part [CHUNKS];
    logic [FOLD_W-1:0] fold_d, fold_q, fold2_q;
    logic [PROD_W-1:0] prod_q;
    logic [QUO_W-1:0]  quo;
    logic [FOLD_W-1:0] rem_full;
    logic [IW-1:0]     rem_q;
    logic [2:0]        vld_q;

    // byte k weighs 2^(8k) mod ENTRIES; the folded sum keeps the residue
    for (genvar k = 0; k < CHUNKS; k++) begin : g_part
      localparam longint unsigned WEIGHT = (64'd1 << (8 * k)) % ENTRIES;
      assign part[k] = PART_W'(pc_i[8*k +: 8]) * PART_W'(WEIGHT);
    end

    always_comb begin
      fold_d = '0;
      for (int k = 0; k < CHUNKS; k++) begin
        fold_d = fold_d + FOLD_W'(part[k]);
      end
    end

    // reciprocal is exact for every folded value, no correction step
    assign quo      = prod_q[PROD_W-1:SHIFT];
    assign rem_full = fold2_q - (FOLD_W'(quo) * FOLD_W'(MODULUS));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= '0;
      end else begin
        vld_q <= {vld_q[1:0], start_i};
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        fold_q <= fold_d;
      end
      if (vld_q[0]) begin
        prod_q  <= PROD_W'(fold_q) * PROD_W'(RECIP);
        fold2_q <= fold_q;
      end
      if (vld_q[1]) begin
        rem_q <= rem_full[IW-1:0];
      end
    end

    assign done_o = vld_q[2];
    assign idx_o  = rem_q;
  end

endmodule

### src/spt_table.sv
// ---------------------------------------------------------------------------
// spt_table: prediction table storage
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module spt_table import spt_pkg::*; #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned IW      = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [IW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/stride_prefetch_table.sv
// ---------------------------------------------------------------------------
// stride_prefetch_table: stride prefetcher reference prediction table
// Result registered after the table read; the index is pipelined for non-power-of-two sizes.
// Throughput: 1 item/cycle for power-of-two sizes via read-modify-write with forwarding
//   if output is free; else one item at a time, held through index reduction and table read.
// Reset: control cleared, then a pass that clears every entry, with input stalled.
// ---------------------------------------------------------------------------
`include "stride_prefetch_table_assert.svh"

module stride_prefetch_table import spt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_IDX, S_UPD} state_e;

  state_e            state_q, state_d;
  logic [IW-1:0]     clr_q, clr_d;
  logic [IW-1:0]     idx_q;
  logic [ADDR_W-1:0] pc_q, addr_q;
  logic              fwd_q;
  entry_t            wr_ent_q;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q;

  logic          accept, out_free, upd_fire;
  logic          rd_en;
  logic [IW-1:0] rd_idx;
  entry_t        rd_ent, ent, new_ent;
  logic          tbl_we;
  logic [IW-1:0] tbl_waddr;
  entry_t        tbl_wdata;
  logic          hit, same, predict;
  logic [STRIDE_W-1:0] nstride;
  out_item_t     result;
  logic          out_none;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign upd_fire   = (state_q == S_UPD) && out_free;
  assign in_stall_o = !((state_q == S_IDLE) || upd_fire);
  assign accept     = in_valid_i && !in_stall_o;

  spt_index #(
    .ENTRIES (TABLE_ENTRIES),
    .IW      (IW)
  ) u_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .pc_i    (in_data_i.instr_addr),
    .done_o  (rd_en),
    .idx_o   (rd_idx)
  );

  assign tbl_we    = (state_q == S_CLR) || upd_fire;
  assign tbl_waddr = (state_q == S_CLR) ? clr_q : idx_q;
  assign tbl_wdata = (state_q == S_CLR) ? entry_t'('0) : new_ent;

  spt_table #(
    .ENTRIES (TABLE_ENTRIES),
    .IW      (IW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_idx),
    .rdata_o (rd_ent)
  );

  // entry written on the same edge as our read overrides stale read data
  assign ent = fwd_q ? wr_ent_q : rd_ent;

  always_comb begin
    hit     = ent.valid && (ent.tag == pc_q);
    nstride = addr_q[STRIDE_W-1:0] - ent.last_addr[STRIDE_W-1:0];
    same    = (nstride == ent.stride);
    predict = 1'b0;
    new_ent = ent;
    new_ent.last_addr = addr_q;
    if (!hit) begin
      new_ent.valid     = 1'b1;
      new_ent.tag       = pc_q;
      new_ent.last_addr = addr_q;
      new_ent.stride    = '0;
      new_ent.conf      = CONF_INIT;
    end else begin
      case (ent.conf)
        CONF_INIT: begin
          new_ent.stride = nstride;
          new_ent.conf   = CONF_TRANSIENT;
          predict        = 1'b1;
        end
        CONF_TRANSIENT: begin
          if (same) begin
            new_ent.conf = CONF_STEADY;
            predict      = 1'b1;
          end else begin
            new_ent.stride = nstride;
            new_ent.conf   = CONF_NOPRED;
          end
        end
        CONF_STEADY: begin
          if (!same) begin
            new_ent.conf = CONF_INIT;
          end
          predict = 1'b1;
        end
        CONF_NOPRED: begin
          if (same) begin
            new_ent.conf = CONF_TRANSIENT;
            predict      = 1'b1;
          end else begin
            new_ent.stride = nstride;
          end
        end
        default: begin
          new_ent.conf = CONF_INIT;
        end
      endcase
    end
    result.prefetch_valid = predict;
    result.prefetch_addr  = predict ?
        (addr_q + {{(ADDR_W-STRIDE_W){nstride[STRIDE_W-1]}}, nstride}) : '0;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_free ? upd_fire : out_valid_q;
    unique case (state_q)
      S_CLR: begin
        clr_d = clr_q + IW'(1);
        if (clr_q == IW'(TABLE_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = rd_en ? S_UPD : S_IDX;
        end
      end
      S_IDX: begin
        if (rd_en) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_fire) begin
          if (accept) begin
            state_d = rd_en ? S_UPD : S_IDX;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      fwd_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (upd_fire) begin
        out_q <= result;
      end
      if (rd_en) begin
        fwd_q <= upd_fire && (idx_q == rd_idx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pc_q   <= in_data_i.instr_addr;
      addr_q <= in_data_i.data_addr;
    end
    if (rd_en) begin
      idx_q <= rd_idx;
    end
    if (upd_fire) begin
      wr_ent_q <= new_ent;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_none    = out_valid_o && !out_data_o.prefetch_valid;

  `SPT_ASSERT_NEXT(a_fwd_set, rd_en && upd_fire && (idx_q == rd_idx), fwd_q, "missed forward")
  `SPT_ASSERT_NEXT(a_miss_quiet, upd_fire && !hit, out_none, "miss predicted")
  `SPT_ASSERT_SAME(a_nopred_zero, out_none, out_data_o.prefetch_addr == '0, "nonzero addr")
  `SPT_ASSERT_SAME(a_read_src, rd_en, (state_q == S_IDX) || accept, "stray table read")
  `SPT_ASSERT_SAME(a_clr_stall, state_q == S_CLR, in_stall_o, "accept during clearing pass")

endmodule
